// ===== rtl/core/sgrs_pkg.sv =====
// Shared types and constants of the safety gain ramp sequencer.
`timescale 1ns / 1ps

package sgrs_pkg;

   // Ramp phase as reported on the result channel
   typedef enum logic [2:0] {
      PH_RUNNING       = 3'd0,
      PH_PANIC_DOWN    = 3'd1,
      PH_PANIC_LATCHED = 3'd2,
      PH_PANIC_UP      = 3'd3,
      PH_RESET_DOWN    = 3'd4,
      PH_RESET_UP      = 3'd5
   } phase_type;

   // Per-frame action codes
   typedef enum logic [1:0] {
      MODE_NONE          = 2'd0,
      MODE_PANIC_PRESS   = 2'd1,
      MODE_PANIC_RELEASE = 2'd2,
      MODE_RESET         = 2'd3
   } mode_type;

   // Frame sequencer states
   typedef enum logic [2:0] {
      SQ_IDLE,
      SQ_ACTION,
      SQ_STEP,
      SQ_SCALE,
      SQ_WRAP,
      SQ_CHECK,
      SQ_EMIT
   } seq_state_type;

   // Serial scaler states
   typedef enum logic [1:0] {
      SC_IDLE,
      SC_MUL,
      SC_ROUND,
      SC_DIV
   } scale_state_type;

   // Commands to the fault window tracker
   typedef struct packed {
      logic clear;    // drop the bad-frame history
      logic advance;  // close the frame, count it
      logic bad;      // the closing frame was bad
   } fault_ctl_type;

   // Register indexes on the CSR port
   localparam logic [1:0] CSR_FALL_FRAMES   = 2'd0;
   localparam logic [1:0] CSR_RISE_FRAMES   = 2'd1;
   localparam logic [1:0] CSR_WINDOW_FRAMES = 2'd2;

   // Register reset values
   localparam logic [15:0] FALL_FRAMES_RESET   = 16'd480;
   localparam logic [15:0] RISE_FRAMES_RESET   = 16'd240;
   localparam logic [19:0] WINDOW_FRAMES_RESET = 20'd48000;

endpackage

// ===== rtl/core/sgrs_serial_scaler.sv =====
// Bit-serial scaler: q = (span * elapsed + length / 2) / length.
`timescale 1ns / 1ps

module sgrs_serial_scaler
   import sgrs_pkg::*;
#(
   parameter int SPAN_WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [SPAN_WIDTH-1:0]    span,
   input  logic [15:0]              elapsed,
   input  logic [15:0]              length,
   output logic                     done,
   output logic [SPAN_WIDTH+15:0]   quotient
);

   localparam int PW = SPAN_WIDTH + 16;
   localparam int CW = $clog2(PW);

   scale_state_type state_ff, state_in;
   logic [PW-1:0]         acc_ff, acc_in;
   logic [15:0]           mul_ff, mul_in;
   logic [SPAN_WIDTH-1:0] span_ff, span_in;
   logic [15:0]           len_ff, len_in;
   logic [15:0]           rem_ff, rem_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  done_ff, done_in;
   logic [16:0]           trial;
   logic                  qbit;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SC_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      mul_ff  <= mul_in;
      span_ff <= span_in;
      len_ff  <= len_in;
      rem_ff  <= rem_in;
   end

   // One multiplier bit, then one quotient bit, per cycle
   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      mul_in   = mul_ff;
      span_in  = span_ff;
      len_in   = len_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      trial    = {rem_ff, acc_ff[PW-1]};
      qbit     = (trial >= {1'b0, len_ff});
      case (state_ff)
         SC_IDLE: begin
            if (start) begin
               span_in  = span;
               mul_in   = elapsed;
               len_in   = length;
               acc_in   = '0;
               cnt_in   = CW'(15);
               state_in = SC_MUL;
            end
         end
         SC_MUL: begin
            // shift-add, multiplier MSB first
            acc_in = {acc_ff[PW-2:0], 1'b0} + (mul_ff[15] ? PW'(span_ff) : '0);
            mul_in = {mul_ff[14:0], 1'b0};
            if (cnt_ff == '0) begin
               state_in = SC_ROUND;
            end else begin
               cnt_in = cnt_ff - CW'(1);
            end
         end
         SC_ROUND: begin
            // bias by half the divisor for round half up
            acc_in   = acc_ff + PW'(len_ff >> 1);
            rem_in   = '0;
            cnt_in   = CW'(PW - 1);
            state_in = SC_DIV;
         end
         SC_DIV: begin
            // restoring divide, quotient bits shift in behind the dividend
            if (qbit) begin
               rem_in = 16'(trial - {1'b0, len_ff});
            end else begin
               rem_in = trial[15:0];
            end
            acc_in = {acc_ff[PW-2:0], qbit};
            if (cnt_ff == '0) begin
               done_in  = 1'b1;
               state_in = SC_IDLE;
            end else begin
               cnt_in = cnt_ff - CW'(1);
            end
         end
         default: begin
            state_in = SC_IDLE;
         end
      endcase
   end

   assign done     = done_ff;
   assign quotient = acc_ff;

endmodule

// ===== rtl/core/sgrs_fault_window.sv =====
// Frame counter and bad-frame history with the three-in-a-window check.
`timescale 1ns / 1ps

module sgrs_fault_window
   import sgrs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic [19:0]   window,
   input  fault_ctl_type ctl,
   output logic          trigger
);

   logic [63:0] frame_ff, frame_in;
   logic [63:0] hist_ff [3];
   logic [63:0] hist_in [3];
   logic [1:0]  count_ff, count_in;
   logic [63:0] diff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff   <= '0;
         hist_ff[0] <= '0;
         hist_ff[1] <= '0;
         hist_ff[2] <= '0;
         count_ff   <= '0;
      end else begin
         frame_ff   <= frame_in;
         hist_ff[0] <= hist_in[0];
         hist_ff[1] <= hist_in[1];
         hist_ff[2] <= hist_in[2];
         count_ff   <= count_in;
      end
   end

   // Span of the triple that this bad frame would close
   assign diff    = frame_ff - ((count_ff == 2'd3) ? hist_ff[1] : hist_ff[0]);
   assign trigger = ctl.advance && ctl.bad && (count_ff >= 2'd2) && (diff < {44'd0, window});

   // Update history
   always_comb begin
      frame_in   = frame_ff;
      hist_in[0] = hist_ff[0];
      hist_in[1] = hist_ff[1];
      hist_in[2] = hist_ff[2];
      count_in   = count_ff;
      if (ctl.clear) begin
         hist_in[0] = '0;
         hist_in[1] = '0;
         hist_in[2] = '0;
         count_in   = '0;
      end else if (ctl.advance) begin
         frame_in = frame_ff + 64'd1;
         if (ctl.bad) begin
            case (count_ff)
               2'd0: begin
                  hist_in[0] = frame_ff;
                  count_in   = 2'd1;
               end
               2'd1: begin
                  hist_in[1] = frame_ff;
                  count_in   = 2'd2;
               end
               2'd2: begin
                  hist_in[2] = frame_ff;
                  count_in   = 2'd3;
               end
               default: begin
                  // full: drop the oldest
                  hist_in[0] = hist_ff[1];
                  hist_in[1] = hist_ff[2];
                  hist_in[2] = frame_ff;
               end
            endcase
         end
      end
   end

endmodule

// ===== rtl/core/safety_gain_ramp_sequencer.sv =====
// Top level of the safety gain ramp sequencer: frame sequencer, CSRs and result register.
`timescale 1ns / 1ps

// Usage
//   One request word per audio frame on req_: the frame's action (none, panic
//   press, panic release, reset request) in tdata and the bad-sample flag in
//   tuser. One response word per request on rsp_: the frame's safety gain
//   (Q1.15, 32768 is unity) and ramp phase in tdata, the reset and panic
//   boundary flags in tuser.
//   Fade lengths and the panic window are to be set over the APB CSR port
//   only while the block is idle; the block itself does not enforce this.
//   Flow: one frame at a time; the next word is accepted once a response
//   is loaded. A frame while running or latched passes the action, step,
//   check and emit states; a zero-length ramp step adds the wrap state,
//   and a frame on a ramp adds the scale and wrap states, where the
//   bit-serial scaler takes 16 multiply steps, one rounding step and one
//   divide step per product bit.
//   The result sits in an output register, so the next frame is accepted
//   and worked while a stalled response waits; that frame then holds in its
//   last step until the output register frees.
//   Reset: synchronous, active high. Gain returns to unity, phase to
//   running, the frame counter and bad-frame history clear, and the CSRs
//   take their reset values.
module safety_gain_ramp_sequencer
   import sgrs_pkg::*;
#(
   parameter int GAIN_FRACTION_BITS = 15
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: [1:0] mode, rest zero
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // req_tuser: [0] bad_sample
   input  logic [0:0]  req_tuser,
   // rsp_tdata: [15:0] gain, [18:16] phase, rest zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,
   // rsp_tuser: [0] reset_done, [1] panic_done
   output logic [1:0]  rsp_tuser,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int GW   = GAIN_FRACTION_BITS + 1;
   localparam int SH_R = (GAIN_FRACTION_BITS >= 15) ? GAIN_FRACTION_BITS - 15 : 0;
   localparam int SH_L = (GAIN_FRACTION_BITS >= 15) ? 0 : 15 - GAIN_FRACTION_BITS;
   localparam logic [GW-1:0] UNITY = {1'b1, {GAIN_FRACTION_BITS{1'b0}}};

   seq_state_type state_ff, state_in;
   phase_type     phase_ff, phase_in;
   mode_type      mode_ff, mode_in;
   logic          bad_ff, bad_in;
   logic [15:0]   elapsed_ff, elapsed_in;
   logic [15:0]   length_ff, length_in;
   logic [GW-1:0] start_ff, start_in;
   logic          goal_ff, goal_in;
   logic [GW-1:0] gain_ff, gain_in;
   logic [GW-1:0] out_gain_ff, out_gain_in;
   logic          rb_ff, rb_in;
   logic          pb_ff, pb_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   rsp_gain_ff, rsp_gain_in;
   phase_type     rsp_phase_ff, rsp_phase_in;
   logic          rsp_rb_ff, rsp_rb_in;
   logic          rsp_pb_ff, rsp_pb_in;
   logic [15:0]   fall_ff, fall_in;
   logic [15:0]   rise_ff, rise_in;
   logic [19:0]   window_ff, window_in;

   logic             csr_write;
   logic             sr_go;
   phase_type        sr_phase;
   logic             sr_goal;
   logic [15:0]      sr_len;
   logic             capture;
   logic [GW-1:0]    goal_gain;
   logic [GW-1:0]    span;
   logic [GW-1:0]    q_clamped;
   logic [15:0]      step_elapsed;
   logic             sc_start;
   logic             sc_done;
   logic [GW+15:0]   sc_quotient;
   fault_ctl_type    fctl;
   logic             trigger;
   logic [GW+15:0]   gain_wide;
   logic [GW+15:0]   gain_shifted;

   // Serial scaler for the ramp interpolation
   sgrs_serial_scaler #(
      .SPAN_WIDTH (GW)
   ) u_scaler (
      .clock    (clock),
      .reset    (reset),
      .start    (sc_start),
      .span     (span),
      .elapsed  (step_elapsed),
      .length   (length_ff),
      .done     (sc_done),
      .quotient (sc_quotient)
   );

   // Bad-frame window tracker
   sgrs_fault_window u_fault (
      .clock   (clock),
      .reset   (reset),
      .window  (window_ff),
      .ctl     (fctl),
      .trigger (trigger)
   );

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SQ_IDLE;
         phase_ff     <= PH_RUNNING;
         elapsed_ff   <= '0;
         length_ff    <= '0;
         start_ff     <= UNITY;
         goal_ff      <= 1'b1;
         gain_ff      <= UNITY;
         rsp_valid_ff <= 1'b0;
         fall_ff      <= FALL_FRAMES_RESET;
         rise_ff      <= RISE_FRAMES_RESET;
         window_ff    <= WINDOW_FRAMES_RESET;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         elapsed_ff   <= elapsed_in;
         length_ff    <= length_in;
         start_ff     <= start_in;
         goal_ff      <= goal_in;
         gain_ff      <= gain_in;
         rsp_valid_ff <= rsp_valid_in;
         fall_ff      <= fall_in;
         rise_ff      <= rise_in;
         window_ff    <= window_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      bad_ff       <= bad_in;
      out_gain_ff  <= out_gain_in;
      rb_ff        <= rb_in;
      pb_ff        <= pb_in;
      rsp_gain_ff  <= rsp_gain_in;
      rsp_phase_ff <= rsp_phase_in;
      rsp_rb_ff    <= rsp_rb_in;
      rsp_pb_ff    <= rsp_pb_in;
   end

   // CSR writes and reads
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      fall_in   = fall_ff;
      rise_in   = rise_ff;
      window_in = window_ff;
      if (csr_write) begin
         case (csr_paddr[3:2])
            CSR_FALL_FRAMES:   fall_in   = csr_pwdata[15:0];
            CSR_RISE_FRAMES:   rise_in   = csr_pwdata[15:0];
            CSR_WINDOW_FRAMES: window_in = csr_pwdata[19:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         CSR_FALL_FRAMES:   csr_prdata = {16'd0, fall_ff};
         CSR_RISE_FRAMES:   csr_prdata = {16'd0, rise_ff};
         CSR_WINDOW_FRAMES: csr_prdata = {12'd0, window_ff};
         default:           csr_prdata = '0;
      endcase
   end

   // Ramp arithmetic shared by the sequencer
   assign goal_gain    = goal_ff ? UNITY : '0;
   assign span         = goal_ff ? UNITY - start_ff : start_ff;
   assign step_elapsed = (elapsed_ff < length_ff) ? elapsed_ff + 16'd1 : elapsed_ff;
   assign q_clamped    = (sc_quotient > (GW+16)'(span)) ? span : sc_quotient[GW-1:0];

   // Bring the held gain to 15 fraction bits
   always_comb begin
      gain_wide = (GW+16)'(out_gain_ff);
      if (GAIN_FRACTION_BITS >= 15) begin
         gain_shifted = gain_wide >> SH_R;
      end else begin
         gain_shifted = gain_wide << SH_L;
      end
   end

   // Frame sequencer: action, ramp step, bad-sample check, emit
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      mode_in      = mode_ff;
      bad_in       = bad_ff;
      elapsed_in   = elapsed_ff;
      length_in    = length_ff;
      start_in     = start_ff;
      goal_in      = goal_ff;
      gain_in      = gain_ff;
      out_gain_in  = out_gain_ff;
      rb_in        = rb_ff;
      pb_in        = pb_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_gain_in  = rsp_gain_ff;
      rsp_phase_in = rsp_phase_ff;
      rsp_rb_in    = rsp_rb_ff;
      rsp_pb_in    = rsp_pb_ff;
      sr_go        = 1'b0;
      sr_phase     = PH_RUNNING;
      sr_goal      = 1'b1;
      sr_len       = '0;
      capture      = 1'b0;
      sc_start     = 1'b0;
      fctl         = '0;
      case (state_ff)
         SQ_IDLE: begin
            if (req_tvalid) begin
               mode_in  = mode_type'(req_tdata[1:0]);
               bad_in   = req_tuser[0];
               state_in = SQ_ACTION;
            end
         end
         SQ_ACTION: begin
            rb_in = 1'b0;
            pb_in = 1'b0;
            case (mode_ff)
               MODE_PANIC_PRESS: begin
                  sr_go    = 1'b1;
                  sr_phase = PH_PANIC_DOWN;
                  sr_goal  = 1'b0;
                  sr_len   = fall_ff;
               end
               MODE_PANIC_RELEASE: begin
                  fctl.clear = 1'b1;
                  sr_go      = 1'b1;
                  sr_phase   = PH_PANIC_UP;
                  sr_goal    = 1'b1;
                  sr_len     = rise_ff;
               end
               MODE_RESET: begin
                  sr_go    = 1'b1;
                  sr_phase = PH_RESET_DOWN;
                  sr_goal  = 1'b0;
                  sr_len   = rise_ff;
               end
               default: begin
               end
            endcase
            state_in = SQ_STEP;
         end
         SQ_STEP: begin
            if (phase_ff == PH_RUNNING || phase_ff == PH_PANIC_LATCHED) begin
               capture  = 1'b1;
               state_in = SQ_CHECK;
            end else if (length_ff == '0) begin
               gain_in  = goal_gain;
               state_in = SQ_WRAP;
            end else begin
               elapsed_in = step_elapsed;
               sc_start   = 1'b1;
               state_in   = SQ_SCALE;
            end
         end
         SQ_SCALE: begin
            if (sc_done) begin
               gain_in  = goal_ff ? start_ff + q_clamped : start_ff - q_clamped;
               state_in = SQ_WRAP;
            end
         end
         SQ_WRAP: begin
            capture  = 1'b1;
            state_in = SQ_CHECK;
            if (!(elapsed_ff < length_ff)) begin
               // ramp done: move to the following phase
               case (phase_ff)
                  PH_RESET_DOWN: begin
                     rb_in    = 1'b1;
                     sr_go    = 1'b1;
                     sr_phase = PH_RESET_UP;
                     sr_goal  = 1'b1;
                     sr_len   = rise_ff;
                  end
                  PH_RESET_UP, PH_PANIC_UP: begin
                     phase_in = PH_RUNNING;
                     gain_in  = UNITY;
                  end
                  PH_PANIC_DOWN: begin
                     phase_in = PH_PANIC_LATCHED;
                     gain_in  = '0;
                     pb_in    = 1'b1;
                  end
                  default: begin
                     phase_in = PH_RUNNING;
                  end
               endcase
            end
         end
         SQ_CHECK: begin
            fctl.advance = 1'b1;
            fctl.bad     = bad_ff;
            if (trigger) begin
               sr_go    = 1'b1;
               sr_phase = PH_PANIC_DOWN;
               sr_goal  = 1'b0;
               sr_len   = fall_ff;
            end
            state_in = SQ_EMIT;
         end
         SQ_EMIT: begin
            // hold until the output register frees
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_gain_in  = gain_shifted[15:0];
               rsp_phase_in = phase_ff;
               rsp_rb_in    = rb_ff;
               rsp_pb_in    = pb_ff;
               state_in     = SQ_IDLE;
            end
         end
         default: begin
            state_in = SQ_IDLE;
         end
      endcase

      // Start a new ramp from the current gain
      if (sr_go) begin
         phase_in   = sr_phase;
         elapsed_in = '0;
         length_in  = sr_len;
         start_in   = gain_in;
         goal_in    = sr_goal;
         if (sr_len == '0) begin
            gain_in = sr_goal ? UNITY : '0;
         end
      end

      // Latch the frame's gain once the ramp step is through
      if (capture) begin
         out_gain_in = gain_in;
      end
   end

   assign req_tready = (state_ff == SQ_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_phase_ff, rsp_gain_ff};
   assign rsp_tuser  = {rsp_pb_ff, rsp_rb_ff};

   // One frame in flight: no accept right after an accept
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while a frame is in work");

   // Held gain never exceeds unity
   assert property (@(posedge clock) disable iff (reset)
      gain_ff <= UNITY)
      else $error("held gain above unity");

   // Both boundaries cannot close in one frame
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("reset and panic boundary in one frame");

   // Panic boundary comes with a silent gain in a panic phase
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |->
         (rsp_tdata[15:0] == 16'd0 &&
          (rsp_tdata[18:16] == PH_PANIC_LATCHED || rsp_tdata[18:16] == PH_PANIC_DOWN)))
      else $error("panic boundary without silent panic phase");

endmodule
